[rtl/lisp_token_scanner_defines.svh]
// ----------------------------------------------------------------------------
// lisp token scanner assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef LISP_TOKEN_SCANNER_DEFINES_SVH
`define LISP_TOKEN_SCANNER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LTS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// expression holds at every edge
`define LTS_ASSERT_HOLD(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

[rtl/lts_pkg.sv]
// ----------------------------------------------------------------------------
// lts_pkg
// shared types and constants of the lisp token scanner
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int OBUF_DEPTH      = 4;

    typedef enum logic [3:0] {
        T_ATOM     = 4'd0,
        T_STRING   = 4'd1,
        T_INT      = 4'd2,
        T_FLOAT    = 4'd3,
        T_SVAR     = 4'd4,
        T_LVAR     = 4'd5,
        T_LPAREN   = 4'd6,
        T_RPAREN   = 4'd7,
        T_NOT      = 4'd8,
        T_OR       = 4'd9,
        T_AND      = 4'd10,
        T_STOP     = 4'd11,
        T_INSTANCE = 4'd12,
        T_UNKNOWN  = 4'd13
    } t_token_type;

    typedef struct packed {
        t_token_type        ttype;
        logic signed [63:0] ival;
        logic [15:0]        len;
        logic               ovf;
        logic               unt;
        logic               last;
    } t_result;

    // up to two results of one word, slot 0 filled first
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_DIV10 = MAG_LIMIT / 10;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ETX    = 8'h03;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

endpackage

[rtl/lisp_token_scanner.sv]
// ----------------------------------------------------------------------------
// lisp_token_scanner
// streaming lisp tokenizer, one character word in, token words out
// ----------------------------------------------------------------------------
// The scanner takes one character word per clock while the result queue has
// room. A word that only extends a token or gives one token gives at most one
// result word; a word that closes a token and starts a one-character token
// gives two result words, written to the queue together and handed out on
// the output port one after the other. Each input word passes an input
// register, the scanner logic and a four-entry result queue. A word is taken
// while the input register is empty or the queue has room for two results,
// so a stalled output side backs up into the input.
// ----------------------------------------------------------------------------
module lisp_token_scanner
    import lts_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // ch
    input  logic        i_s_tuser,  // end_of_input
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,  // int_value, token_length, int_overflow, string_unterminated
    output logic [3:0]  o_m_tuser,  // token_type
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data  // instance_names_enable
);

    logic    r_inst_en;
    logic    room;
    t_push   push;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inst_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_inst_en <= i_cfg_data;
        end
    end

    lts_scan #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_ch     (i_s_tdata),
        .i_eof    (i_s_tuser),
        .i_inst_en(r_inst_en),
        .i_room   (room),
        .o_push   (push)
    );

    lts_obuf u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_room (room),
        .o_valid(o_m_tvalid),
        .i_ready(i_m_tready),
        .o_res  (res)
    );

    assign o_m_tdata = {6'd0, res.unt, res.ovf, res.len, res.ival};
    assign o_m_tuser = res.ttype;
    assign o_m_tlast = res.last;

endmodule

[rtl/lts_scan.sv]
// ----------------------------------------------------------------------------
// lts_scan
// input word register, per-character scanner state and result forming
// ----------------------------------------------------------------------------
`include "lisp_token_scanner_defines.svh"

module lts_scan
    import lts_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_eof,
    input  logic       i_inst_en,
    input  logic       i_room,
    output t_push      o_push
);

    localparam int LW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
    localparam logic [LENGTH_BITS-1:0] LEN_CAP = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

    typedef enum logic [2:0] {
        M_IDLE, M_COMMENT, M_ATOM, M_STRING, M_ESCAPE, M_NUMBER, M_VARMARK
    } t_mode;

    logic                   r_in_valid;
    logic [7:0]             r_ch;
    logic                   r_eof;

    t_mode                  r_mode, n_mode;
    logic [1:0]             r_phase, n_phase;
    logic                   r_digit, n_digit;
    logic                   r_float, n_float;
    logic [1:0]             r_vkind, n_vkind;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_fbrk, n_fbrk;
    logic [7:0]             r_prev, n_prev;
    logic [63:0]            r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic                   r_clamp, n_clamp;

    logic        adv;
    logic        is_dig, is_alpha, is_print, atom_delim, num_delim;
    logic [63:0] dig_val, mag10, mag_sum, acc_mag, neg_val, pos_val, int_val;
    logic        acc_clamp;
    logic [15:0] len16;
    logic [LW-1:0] len_wide;
    logic [LENGTH_BITS-1:0] len_inc;
    t_token_type atom_type;

    logic    fin_v, idl_v, do_idle, take, ds;
    t_result fin, idl;

    assign adv     = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;

    // character classes
    assign is_dig    = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign is_alpha  = ((r_ch >= 8'h61) && (r_ch <= 8'h7A)) || ((r_ch >= 8'h41) && (r_ch <= 8'h5A));
    assign is_print  = (r_ch >= CH_SPACE) && (r_ch <= CH_TILDE);
    assign atom_delim = !is_print ||
        (r_ch inside {CH_QUOTE, CH_LPAR, CH_RPAR, CH_AMP, CH_BAR, CH_TILDE, CH_SPACE, CH_SEMI});
    assign num_delim = r_eof || atom_delim || (r_ch == CH_LT);

    // decimal accumulate, x*10 as two shifts
    assign dig_val   = {60'd0, r_ch[3:0]};
    assign mag10     = {r_mag[60:0], 3'b000} + {r_mag[62:0], 1'b0};
    assign mag_sum   = mag10 + dig_val;
    assign acc_clamp = r_clamp || (r_mag > MAG_DIV10) || (mag_sum > MAG_LIMIT);
    assign acc_mag   = acc_clamp ? MAG_LIMIT : mag_sum;

    assign neg_val = (r_mag >= MAG_LIMIT) ? MAG_LIMIT : (64'd0 - r_mag);
    assign pos_val = (r_mag > POS_MAX) ? POS_MAX : r_mag;
    assign int_val = r_neg ? neg_val : pos_val;

    assign len_wide = LW'(r_len);
    assign len16    = (len_wide > LW'(16'hFFFF)) ? 16'hFFFF : len_wide[15:0];
    assign len_inc  = (r_len != LEN_CAP) ? (r_len + LEN_ONE) : r_len;

    always_comb begin
        if (r_vkind == 2'd1) begin
            atom_type = T_SVAR;
        end else if (r_vkind == 2'd2) begin
            atom_type = T_LVAR;
        end else if (i_inst_en && r_fbrk && (r_prev == CH_RBRK) &&
                     (r_len > LENGTH_BITS'(2))) begin
            atom_type = T_INSTANCE;
        end else begin
            atom_type = T_ATOM;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_digit = r_digit;
        n_float = r_float;
        n_vkind = r_vkind;
        n_len   = r_len;
        n_fbrk  = r_fbrk;
        n_prev  = r_prev;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_clamp = r_clamp;
        fin_v   = 1'b0;
        idl_v   = 1'b0;
        do_idle = 1'b0;
        take    = 1'b0;
        ds      = r_digit;
        fin     = '{ttype: T_ATOM, ival: '0, len: len16, ovf: 1'b0, unt: 1'b0, last: 1'b0};
        idl     = '{ttype: T_STOP, ival: '0, len: 16'd1, ovf: 1'b0, unt: 1'b0, last: 1'b1};

        case (r_mode)
            M_COMMENT: begin
                if (r_eof) begin
                    do_idle = 1'b1;
                end else if ((r_ch == CH_LF) || (r_ch == CH_CR)) begin
                    n_mode = M_IDLE;
                end
            end
            M_ATOM: begin
                if (!r_eof && !atom_delim) begin
                    n_len  = len_inc;
                    n_prev = r_ch;
                end else begin
                    fin_v     = 1'b1;
                    fin.ttype = atom_type;
                    do_idle   = 1'b1;
                end
            end
            M_STRING, M_ESCAPE: begin
                if (r_eof) begin
                    fin_v     = 1'b1;
                    fin.ttype = T_STRING;
                    fin.unt   = 1'b1;
                    do_idle   = 1'b1;
                end else if (r_mode == M_ESCAPE) begin
                    n_len  = len_inc;
                    n_prev = r_ch;
                    n_mode = M_STRING;
                end else if (r_ch == CH_QUOTE) begin
                    fin_v     = 1'b1;
                    fin.ttype = T_STRING;
                    do_idle   = 1'b1;
                    idl_v     = 1'b0;
                end else if (r_ch == CH_BSLASH) begin
                    n_mode = M_ESCAPE;
                end else begin
                    n_len  = len_inc;
                    n_prev = r_ch;
                end
            end
            M_NUMBER: begin
                case (r_phase)
                    2'd0: begin
                        if (!r_eof && is_dig) begin
                            n_digit = 1'b1;
                            n_mag   = acc_mag;
                            n_clamp = acc_clamp;
                            take    = 1'b1;
                        end else if (!r_eof && (r_ch == CH_DOT)) begin
                            n_float = 1'b1;
                            n_phase = 2'd1;
                            take    = 1'b1;
                        end else if (!r_eof && ((r_ch == CH_LO_E) || (r_ch == CH_UP_E))) begin
                            n_float = 1'b1;
                            n_phase = 2'd2;
                            take    = 1'b1;
                        end
                    end
                    2'd1: begin
                        if (!r_eof && is_dig) begin
                            n_digit = 1'b1;
                            take    = 1'b1;
                        end else if (!r_eof && ((r_ch == CH_LO_E) || (r_ch == CH_UP_E))) begin
                            n_phase = 2'd2;
                            take    = 1'b1;
                        end
                    end
                    2'd2: begin
                        if (!r_eof && (is_dig || (r_ch == CH_PLUS) || (r_ch == CH_MINUS))) begin
                            n_phase = 2'd3;
                            take    = 1'b1;
                        end else if (num_delim) begin
                            ds = 1'b0;
                        end
                    end
                    default: begin
                        if (!r_eof && is_dig) begin
                            take = 1'b1;
                        end else if (num_delim &&
                                     ((r_prev == CH_PLUS) || (r_prev == CH_MINUS))) begin
                            ds = 1'b0;
                        end
                    end
                endcase
                if (take) begin
                    n_len  = len_inc;
                    n_prev = r_ch;
                end else if (num_delim) begin
                    fin_v = 1'b1;
                    if (!ds) begin
                        fin.ttype = T_ATOM;
                    end else if (r_float) begin
                        fin.ttype = T_FLOAT;
                    end else begin
                        fin.ttype = T_INT;
                        fin.ival  = int_val;
                        fin.ovf   = (int_val == POS_MAX) || (int_val == MAG_LIMIT);
                    end
                    do_idle = 1'b1;
                end else begin
                    // number text turns into an atom
                    n_mode  = M_ATOM;
                    n_vkind = 2'd0;
                    n_fbrk  = 1'b0;
                    n_len   = len_inc;
                    n_prev  = r_ch;
                end
            end
            M_VARMARK: begin
                if (!r_eof && is_alpha) begin
                    n_mode = M_ATOM;
                    n_len  = len_inc;
                    n_prev = r_ch;
                end else begin
                    fin_v     = 1'b1;
                    fin.ttype = T_UNKNOWN;
                    fin.len   = 16'd1;
                    do_idle   = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // closing quote only clears state, no second token
        if ((r_mode == M_STRING) && !r_eof && (r_ch == CH_QUOTE)) begin
            do_idle = 1'b0;
            n_mode  = M_IDLE;
            n_len   = '0;
            n_prev  = '0;
        end

        if (do_idle) begin
            n_mode  = M_IDLE;
            n_phase = 2'd0;
            n_digit = 1'b0;
            n_float = 1'b0;
            n_vkind = 2'd0;
            n_len   = '0;
            n_fbrk  = 1'b0;
            n_prev  = '0;
            n_mag   = '0;
            n_neg   = 1'b0;
            n_clamp = 1'b0;
            if (r_eof || (r_ch == CH_NUL) || (r_ch == CH_ETX)) begin
                idl_v   = 1'b1;
                idl.len = 16'd0;
            end else if (r_ch inside {CH_SPACE, CH_LF, CH_FF, CH_CR, CH_TAB}) begin
                idl_v = 1'b0;
            end else if (r_ch == CH_SEMI) begin
                n_mode = M_COMMENT;
            end else if (is_dig) begin
                n_mode  = M_NUMBER;
                n_digit = 1'b1;
                n_mag   = dig_val;
                n_len   = LEN_ONE;
                n_prev  = r_ch;
            end else if ((r_ch == CH_PLUS) || (r_ch == CH_MINUS)) begin
                n_mode = M_NUMBER;
                n_neg  = (r_ch == CH_MINUS);
                n_len  = LEN_ONE;
                n_prev = r_ch;
            end else if (r_ch == CH_DOT) begin
                n_mode  = M_NUMBER;
                n_phase = 2'd1;
                n_float = 1'b1;
                n_len   = LEN_ONE;
                n_prev  = r_ch;
            end else if (r_ch == CH_QUOTE) begin
                n_mode = M_STRING;
            end else if ((r_ch == CH_DOLLAR) || (r_ch == CH_AT)) begin
                n_mode  = M_VARMARK;
                n_vkind = (r_ch == CH_DOLLAR) ? 2'd1 : 2'd2;
                n_len   = LEN_ONE;
                n_prev  = r_ch;
            end else if (r_ch == CH_LPAR) begin
                idl_v     = 1'b1;
                idl.ttype = T_LPAREN;
            end else if (r_ch == CH_RPAR) begin
                idl_v     = 1'b1;
                idl.ttype = T_RPAREN;
            end else if (r_ch == CH_TILDE) begin
                idl_v     = 1'b1;
                idl.ttype = T_NOT;
            end else if (r_ch == CH_BAR) begin
                idl_v     = 1'b1;
                idl.ttype = T_OR;
            end else if (r_ch == CH_AMP) begin
                idl_v     = 1'b1;
                idl.ttype = T_AND;
            end else if (is_print) begin
                n_mode = M_ATOM;
                n_fbrk = (r_ch == CH_LBRK);
                n_len  = LEN_ONE;
                n_prev = r_ch;
            end else begin
                idl_v     = 1'b1;
                idl.ttype = T_UNKNOWN;
            end
        end

        fin.last = !idl_v;
    end

    always_comb begin
        o_push.v0 = adv && (fin_v || idl_v);
        o_push.v1 = adv && fin_v && idl_v;
        o_push.r0 = fin_v ? fin : idl;
        o_push.r1 = idl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_phase    <= 2'd0;
            r_digit    <= 1'b0;
            r_float    <= 1'b0;
            r_vkind    <= 2'd0;
            r_len      <= '0;
            r_fbrk     <= 1'b0;
            r_prev     <= '0;
            r_mag      <= '0;
            r_neg      <= 1'b0;
            r_clamp    <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_mode  <= n_mode;
                r_phase <= n_phase;
                r_digit <= n_digit;
                r_float <= n_float;
                r_vkind <= n_vkind;
                r_len   <= n_len;
                r_fbrk  <= n_fbrk;
                r_prev  <= n_prev;
                r_mag   <= n_mag;
                r_neg   <= n_neg;
                r_clamp <= n_clamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ch  <= i_ch;
            r_eof <= i_eof;
        end
    end

    `LTS_ASSERT_IMP(a_idle_clear, r_mode == M_IDLE, (r_len == '0) && (r_mag == '0) && !r_clamp, "idle state not cleared")
    `LTS_ASSERT_IMP(a_two_order, o_push.v1, o_push.v0 && !o_push.r0.last && o_push.r1.last, "second result out of order")
    `LTS_ASSERT_IMP(a_ovf_int, o_push.v0 && o_push.r0.ovf, o_push.r0.ttype == T_INT, "overflow flag on non-integer")

endmodule

[rtl/lts_obuf.sv]
// ----------------------------------------------------------------------------
// lts_obuf
// small result queue, takes up to two results a cycle, hands out one
// ----------------------------------------------------------------------------
`include "lisp_token_scanner_defines.svh"

module lts_obuf
    import lts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    localparam int PW = $clog2(OBUF_DEPTH);
    localparam int CW = $clog2(OBUF_DEPTH + 1);
    localparam logic [CW-1:0] CNT_ROOM = CW'(OBUF_DEPTH - 2);
    localparam logic [CW-1:0] CNT_MAX  = CW'(OBUF_DEPTH);

    t_result       r_mem [OBUF_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic [PW-1:0] wp_next;
    logic          pop;
    logic [CW-1:0] n_push;

    assign o_room  = (r_count <= CNT_ROOM);
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    assign wp_next = r_wp + PW'(1);
    assign n_push  = CW'(i_push.v0) + CW'(i_push.v1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PW'(n_push);
            r_rp    <= r_rp + PW'(pop);
            r_count <= r_count + n_push - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wp_next] <= i_push.r1;
        end
    end

    `LTS_ASSERT_HOLD(a_cnt_max, r_count <= CNT_MAX, "result queue overrun")
    `LTS_ASSERT_IMP(a_push_room, i_push.v0, r_count <= CNT_ROOM, "push without room")
    `LTS_ASSERT_IMP(a_pair, i_push.v1, i_push.v0, "second slot without first")

endmodule
